// ===== hdl/leb_pkg.sv =====
`default_nettype none

package leb_pkg;

   localparam int LEB_BUFFER_SIZE = 64;
   localparam int CHAR_W          = 7;

   localparam logic [6:0] LIMIT_RESET = 7'd64;
   localparam logic [6:0] SPACE_CODE  = 7'd32;

   localparam logic [3:0] KIND_CHAR   = 4'd0;
   localparam logic [3:0] KIND_RETURN = 4'd1;
   localparam logic [3:0] KIND_ESCAPE = 4'd2;
   localparam logic [3:0] KIND_BKSP   = 4'd3;
   localparam logic [3:0] KIND_DELETE = 4'd4;
   localparam logic [3:0] KIND_LEFT   = 4'd5;
   localparam logic [3:0] KIND_RIGHT  = 4'd6;
   localparam logic [3:0] KIND_HOME   = 4'd7;
   localparam logic [3:0] KIND_END    = 4'd8;
   localparam logic [3:0] KIND_BEGIN  = 4'd9;
   localparam logic [3:0] KIND_READ   = 4'd10;

   // ) ! @ # $ % ^ & * (
   localparam logic [6:0] SHIFTED_DIGITS [0:9] = '{
      7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
   };

   // Key code to ASCII; zero means the key has no character.
   function automatic logic [6:0] map_key(input logic [6:0] code, input logic sh);
      logic [6:0] ch;
      ch = '0;
      case (code) inside
         [7'h41:7'h5A]: ch = sh ? code : code + 7'd32;
         [7'h30:7'h39]: ch = sh ? SHIFTED_DIGITS[4'(code - 7'h30)] : code;
         SPACE_CODE:    ch = SPACE_CODE;
         7'h2D:         ch = sh ? 7'h5F : 7'h2D;
         7'h3D:         ch = sh ? 7'h2B : 7'h3D;
         7'h5B:         ch = sh ? 7'h7B : 7'h5B;
         7'h5D:         ch = sh ? 7'h7D : 7'h5D;
         7'h3B:         ch = sh ? 7'h3A : 7'h3B;
         7'h27:         ch = sh ? 7'h22 : 7'h27;
         7'h2C:         ch = sh ? 7'h3C : 7'h2C;
         7'h2E:         ch = sh ? 7'h3E : 7'h2E;
         7'h2F:         ch = sh ? 7'h3F : 7'h2F;
         7'h5C:         ch = sh ? 7'h7C : 7'h5C;
         7'h60:         ch = sh ? 7'h7E : 7'h60;
         default:       ch = '0;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/leb_ifs.sv =====
`default_nettype none

interface leb_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] kind;
   logic [6:0] scan_code;
   logic       shift;
   logic [5:0] read_index;

   modport source (output valid, kind, scan_code, shift, read_index, input ready);
   modport sink   (input valid, kind, scan_code, shift, read_index, output ready);
endinterface

interface leb_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_out;
   logic [5:0] length_now;
   logic [5:0] cursor_now;
   logic       is_active;
   logic       was_confirmed;
   logic       was_cancelled;

   modport source (output valid, char_out, length_now, cursor_now, is_active,
                    was_confirmed, was_cancelled, input ready);
   modport sink   (input valid, char_out, length_now, cursor_now, is_active,
                    was_confirmed, was_cancelled, output ready);
endinterface

`default_nettype wire

// ===== hdl/leb_ram.sv =====
`default_nettype none

module leb_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/line_edit_buffer.sv =====
`default_nettype none
// Line-editing text buffer driven by key event words.
// req_port carries one key event per word (kind, scan_code, shift, read_index);
// rsp_port returns exactly one result word per event: the inserted or read
// character and the length, cursor and session flags after the event.
// csr_* is an APB-style port; length_limit sits at byte address 0 and is to be
// written by the user only while the block is idle, which is not enforced.
// Each event passes from idle to the finish state: directly for cursor moves,
// flags, begin and dropped keys, through a RAM read wait for a read, and
// through the shift state for an insert, delete or backspace, which moves n
// entries (n is length - cursor for an insert or backspace, one less for a
// delete). The tail of the text is moved through the single text RAM, one
// entry per cycle.
// An event is taken only while no edit is in progress; a finished result
// waits in the output register, and a new event is taken meanwhile. When
// the receiver stalls, the next result is held until the register frees.
// Reset closes the session, empties the text and sets length_limit to 64.
// Entries at or beyond the current length read as zero, so neither reset
// nor begin needs to sweep the RAM.
module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int BUFFER_SIZE = LEB_BUFFER_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   leb_req_if.sink          req_port,
   leb_rsp_if.source        rsp_port,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int IW = $clog2(BUFFER_SIZE);
   localparam int LW = $clog2(BUFFER_SIZE + 1);
   localparam int CW = (LW > 7) ? LW : 7;
   localparam int XW = (IW > 6) ? IW : 6;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RDWAIT = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [6:0]        lim_reg_ff, lim_reg_in;
   logic [LW-1:0]     limit_ff, limit_in;
   logic [IW-1:0]     len_ff, len_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic              active_ff, active_in;
   logic              conf_ff, conf_in;
   logic              canc_ff, canc_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]     src_ff, src_in;
   logic [IW-1:0]     dst_ff, dst_in;
   logic              dir_right_ff, dir_right_in;
   logic              ins_ff, ins_in;
   logic [IW-1:0]     chr_pos_ff, chr_pos_in;
   logic [CHAR_W-1:0] res_char_ff, res_char_in;
   logic              hit_ff, hit_in;

   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic [5:0]        out_len_ff, out_len_in;
   logic [5:0]        out_cur_ff, out_cur_in;
   logic              out_act_ff, out_act_in;
   logic              out_conf_ff, out_conf_in;
   logic              out_canc_ff, out_canc_in;

   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic [IW-1:0]     ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   logic [CHAR_W-1:0] mapped;
   logic [LW-1:0]     limit_cap;
   logic              full;
   logic              csr_wr;

   leb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BUFFER_SIZE)
   ) u_text (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {25'd0, lim_reg_ff} : 32'd0;

   assign mapped    = map_key(req_port.scan_code, req_port.shift);
   assign limit_cap = (CW'(lim_reg_ff) < CW'(BUFFER_SIZE)) ? LW'(lim_reg_ff)
                                                           : LW'(BUFFER_SIZE);
   assign full      = ((LW + 1)'(len_ff) + (LW + 1)'(1)) >= (LW + 1)'(limit_ff);

   assign req_port.ready = (state_ff == ST_IDLE);

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.char_out      = out_char_ff;
   assign rsp_port.length_now    = out_len_ff;
   assign rsp_port.cursor_now    = out_cur_ff;
   assign rsp_port.is_active     = out_act_ff;
   assign rsp_port.was_confirmed = out_conf_ff;
   assign rsp_port.was_cancelled = out_canc_ff;

   always_comb begin
      state_in     = state_ff;
      lim_reg_in   = lim_reg_ff;
      limit_in     = limit_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      conf_in      = conf_ff;
      canc_in      = canc_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      dir_right_in = dir_right_ff;
      ins_in       = ins_ff;
      chr_pos_in   = chr_pos_ff;
      res_char_in  = res_char_ff;
      hit_in       = hit_ff;
      out_char_in  = out_char_ff;
      out_len_in   = out_len_ff;
      out_cur_in   = out_cur_ff;
      out_act_in   = out_act_ff;
      out_conf_in  = out_conf_ff;
      out_canc_in  = out_canc_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_addr  = src_ff;

      if (csr_wr && (csr_paddr[2] == 1'b0)) begin
         lim_reg_in = csr_pwdata[6:0];
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = IW'(req_port.read_index);
            pend_in     = 1'b0;
            if (req_port.valid) begin
               res_char_in = '0;
               state_in    = ST_FINISH;
               case (req_port.kind)
                  KIND_BEGIN: begin
                     len_in    = '0;
                     cur_in    = '0;
                     limit_in  = limit_cap;
                     active_in = 1'b1;
                     conf_in   = 1'b0;
                     canc_in   = 1'b0;
                  end
                  KIND_READ: begin
                     hit_in   = XW'(req_port.read_index) < XW'(len_ff);
                     state_in = ST_RDWAIT;
                  end
                  default: begin
                     if (active_ff) begin
                        case (req_port.kind)
                           KIND_CHAR: begin
                              if ((mapped != '0) && !full) begin
                                 res_char_in  = mapped;
                                 dir_right_in = 1'b1;
                                 ins_in       = 1'b1;
                                 cnt_in       = len_ff - cur_ff;
                                 src_in       = len_ff - IW'(1);
                                 chr_pos_in   = cur_ff;
                                 cur_in       = cur_ff + IW'(1);
                                 len_in       = len_ff + IW'(1);
                                 state_in     = ST_SHIFT;
                              end
                           end
                           KIND_RETURN: begin
                              conf_in   = 1'b1;
                              active_in = 1'b0;
                           end
                           KIND_ESCAPE: begin
                              canc_in   = 1'b1;
                              active_in = 1'b0;
                           end
                           KIND_BKSP: begin
                              // step back, then drop the entry now under the cursor
                              if (cur_ff != '0) begin
                                 dir_right_in = 1'b0;
                                 ins_in       = 1'b0;
                                 cnt_in       = len_ff - cur_ff;
                                 src_in       = cur_ff;
                                 cur_in       = cur_ff - IW'(1);
                                 len_in       = len_ff - IW'(1);
                                 state_in     = ST_SHIFT;
                              end
                           end
                           KIND_DELETE: begin
                              if (cur_ff < len_ff) begin
                                 dir_right_in = 1'b0;
                                 ins_in       = 1'b0;
                                 cnt_in       = len_ff - cur_ff - IW'(1);
                                 src_in       = cur_ff + IW'(1);
                                 len_in       = len_ff - IW'(1);
                                 state_in     = ST_SHIFT;
                              end
                           end
                           KIND_LEFT: begin
                              if (cur_ff != '0) begin
                                 cur_in = cur_ff - IW'(1);
                              end
                           end
                           KIND_RIGHT: begin
                              if (cur_ff < len_ff) begin
                                 cur_in = cur_ff + IW'(1);
                              end
                           end
                           KIND_HOME: begin
                              cur_in = '0;
                           end
                           KIND_END: begin
                              cur_in = len_ff;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
               endcase
            end
         end

         ST_RDWAIT: begin
            res_char_in = hit_ff ? ram_rd_data : '0;
            state_in    = ST_FINISH;
         end

         ST_SHIFT: begin
            // write back the word read last cycle, one step behind the read
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (cnt_ff != '0) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff - IW'(1);
               dst_in  = dir_right_ff ? src_ff + IW'(1) : src_ff - IW'(1);
               src_in  = dir_right_ff ? src_ff - IW'(1) : src_ff + IW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (ins_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = chr_pos_ff;
                     ram_wr_data = res_char_ff;
                  end
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               out_char_in  = res_char_ff;
               out_len_in   = 6'(len_ff);
               out_cur_in   = 6'(cur_ff);
               out_act_in   = active_ff;
               out_conf_in  = conf_ff;
               out_canc_in  = canc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lim_reg_ff   <= LIMIT_RESET;
         limit_ff     <= LW'(BUFFER_SIZE);
         len_ff       <= '0;
         cur_ff       <= '0;
         active_ff    <= 1'b0;
         conf_ff      <= 1'b0;
         canc_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lim_reg_ff   <= lim_reg_in;
         limit_ff     <= limit_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         active_ff    <= active_in;
         conf_ff      <= conf_in;
         canc_ff      <= canc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      dir_right_ff <= dir_right_in;
      ins_ff       <= ins_in;
      chr_pos_ff   <= chr_pos_in;
      res_char_ff  <= res_char_in;
      hit_ff       <= hit_in;
      out_char_ff  <= out_char_in;
      out_len_ff   <= out_len_in;
      out_cur_ff   <= out_cur_in;
      out_act_ff   <= out_act_in;
      out_conf_ff  <= out_conf_in;
      out_canc_ff  <= out_canc_in;
   end

endmodule

`default_nettype wire
